// ===== src/lsa_pkg.sv =====
// lsa_pkg: sizes, codes and shared structs for the LRU slot allocator.
// Used by lsa_cell and lru_slot_allocator; depends on nothing.
`default_nettype none
package lsa_pkg;

  localparam int SLOTS   = 8;
  localparam int ID_BITS = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_TOUCH   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_GRANT_FREE  = 2'd0,
    ST_GRANT_EVICT = 2'd1,
    ST_NONE        = 2'd2,
    ST_DONE        = 2'd3
  } status_t;

  // HEAD installs a new occupant at most recent; MOVE reorders and keeps it.
  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_HEAD = 2'd1,
    UPD_FREE = 2'd2,
    UPD_MOVE = 2'd3
  } upd_op_t;

  // Search result handed from one cell to the next.
  typedef struct packed {
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic               ev_found;
    logic [SLOT_W-1:0]  ev_idx;
    logic [SLOT_W-1:0]  ev_rank;
    logic [ID_BITS-1:0] ev_id;
  } scan_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    upd_op_t            op;
    logic [SLOT_W-1:0]  tgt;
    logic [SLOT_W-1:0]  tgt_rank;
    logic               tgt_busy;
    logic [ID_BITS-1:0] new_id;
  } upd_t;

endpackage
`default_nettype wire

// ===== src/lsa_cell.sv =====
// lsa_cell: one slot of the allocator: busy flag, occupant and recency rank.
// Extends the free/eviction search chain and applies broadcast updates. Uses lsa_pkg.
`default_nettype none
module lsa_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [lsa_pkg::SLOT_W-1:0]  cell_idx,
  input  wire logic [lsa_pkg::ID_BITS-1:0] req_id,
  input  wire logic                        high,
  input  wire lsa_pkg::scan_t              scan_in,
  output lsa_pkg::scan_t                   scan_out,
  input  wire lsa_pkg::upd_t               upd,
  output logic                             busy,
  output logic [lsa_pkg::SLOT_W-1:0]       rank
);
  import lsa_pkg::*;

  logic               busy_r, busy_nxt;
  logic [SLOT_W-1:0]  rank_r, rank_nxt;
  logic [ID_BITS-1:0] occ_r, occ_nxt;
  logic               may_use, free_ok, ev_ok, is_tgt;

  assign may_use = (cell_idx != '0) || high;
  assign free_ok = !busy_r && may_use;
  assign ev_ok   = busy_r && may_use && (occ_r != req_id);

  always_comb begin
    scan_out = scan_in;
    if (!scan_in.free_found && free_ok) begin
      scan_out.free_found = 1'b1;
      scan_out.free_idx   = cell_idx;
    end
    // ranks are unique, so the oldest eligible slot wins on a strict compare
    if (ev_ok && (!scan_in.ev_found || rank_r > scan_in.ev_rank)) begin
      scan_out.ev_found = 1'b1;
      scan_out.ev_idx   = cell_idx;
      scan_out.ev_rank  = rank_r;
      scan_out.ev_id    = occ_r;
    end
  end

  assign is_tgt = (upd.tgt == cell_idx);

  always_comb begin
    busy_nxt = busy_r;
    rank_nxt = rank_r;
    occ_nxt  = occ_r;
    case (upd.op)
      UPD_HEAD, UPD_MOVE: begin
        if (is_tgt) begin
          busy_nxt = 1'b1;
          rank_nxt = '0;
          if (upd.op == UPD_HEAD) occ_nxt = upd.new_id;
        end else if (busy_r && (!upd.tgt_busy || rank_r < upd.tgt_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      UPD_FREE: begin
        if (is_tgt) begin
          busy_nxt = 1'b0;
          rank_nxt = '0;
          occ_nxt  = '0;
        end else if (busy_r && rank_r > upd.tgt_rank) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rank_r <= '0;
      occ_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rank_r <= rank_nxt;
      occ_r  <= occ_nxt;
    end
  end

  assign busy = busy_r;
  assign rank = rank_r;

endmodule
`default_nettype wire

// ===== src/lru_slot_allocator.sv =====
// lru_slot_allocator: top level; input register, control sequencer, row of cells.
// Depends on lsa_pkg and lsa_cell.
`default_nettype none
// Slot allocator over a pool of SLOTS slots kept in least-recently-used order;
// slot 0 is reserved for high-priority requesters. Each transaction on the in_
// channel is an acquire, touch or release and yields exactly one transaction on
// the out_ channel with a status, the granted slot, the evicted occupant and the
// busy count after the step. The accept cycle registers the request, and the
// execute cycle ripples the free-slot and eviction search through the row of slot
// cells (one cell per slot, lowest index first) and commits the recency update
// into all cells at its end. The next request is accepted in the cycle after
// execute, so a new request is not taken before the current one has executed;
// the out_ register lets a result wait for out_ready while the next request is
// already taken. A pending result that is not yet taken holds the execute cycle
// until the out_ register frees up.
module lru_slot_allocator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_requester_id,
  input  wire logic       in_high_priority,
  input  wire logic [3:0] in_slot_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [2:0]      out_slot_out,
  output logic [7:0]      out_evicted_id,
  output logic [3:0]      out_busy_count
);
  import lsa_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t             state_r;
  logic [1:0]         act_r;
  logic [ID_BITS-1:0] req_r;
  logic               high_r;
  logic [3:0]         idx_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [2:0]         slot_r, slot_nxt;
  logic [7:0]         evict_r, evict_nxt;
  logic [3:0]         busy_cnt_r;

  scan_t              scan [SLOTS+1];
  upd_t               upd;
  logic [SLOTS-1:0]   busy_vec;
  logic [SLOT_W-1:0]  rank_w [SLOTS];

  logic               go, in_fire, idx_ok, tgt_busy;
  logic [SLOT_W-1:0]  sel;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  // Execute only once the out_ register can take the result.
  assign go = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Row of slot cells; the search chain starts empty at slot 0.
  assign scan[0] = '0;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(g)),
      .req_id   (req_r),
      .high     (high_r),
      .scan_in  (scan[g]),
      .scan_out (scan[g+1]),
      .upd      (upd),
      .busy     (busy_vec[g]),
      .rank     (rank_w[g])
    );
  end

  // Touch/release target: non-negative and inside the pool.
  assign idx_ok   = !idx_r[3] && (32'(idx_r[2:0]) < SLOTS);
  assign sel      = SLOT_W'(idx_r[2:0]);
  assign tgt_busy = busy_vec[sel];

  always_comb begin
    upd        = '0;
    upd.op     = UPD_NONE;
    upd.new_id = req_r;
    status_nxt = ST_DONE;
    slot_nxt   = '0;
    evict_nxt  = '0;
    cnt_nxt    = cnt_r;
    case (act_r)
      ACT_ACQUIRE: begin
        if (scan[SLOTS].free_found) begin
          status_nxt   = ST_GRANT_FREE;
          slot_nxt     = 3'(scan[SLOTS].free_idx);
          upd.op       = UPD_HEAD;
          upd.tgt      = scan[SLOTS].free_idx;
          upd.tgt_busy = 1'b0;
          cnt_nxt      = cnt_r + 1'b1;
        end else if (scan[SLOTS].ev_found) begin
          status_nxt   = ST_GRANT_EVICT;
          slot_nxt     = 3'(scan[SLOTS].ev_idx);
          evict_nxt    = 8'(scan[SLOTS].ev_id);
          upd.op       = UPD_HEAD;
          upd.tgt      = scan[SLOTS].ev_idx;
          upd.tgt_rank = scan[SLOTS].ev_rank;
          upd.tgt_busy = 1'b1;
        end else begin
          status_nxt = ST_NONE;
        end
      end
      ACT_TOUCH: begin
        // Reorder only; the occupant stays as it is.
        if (idx_ok && tgt_busy) begin
          upd.op       = UPD_MOVE;
          upd.tgt      = sel;
          upd.tgt_rank = rank_w[sel];
          upd.tgt_busy = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (idx_ok && tgt_busy) begin
          upd.op       = UPD_FREE;
          upd.tgt      = sel;
          upd.tgt_rank = rank_w[sel];
          upd.tgt_busy = 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
        end
      end
      default: ;
    endcase
    // Hold every cell unless a request executes now (idle, or execute waiting).
    if (!go) begin
      upd.op  = UPD_NONE;
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      status_r    <= ST_DONE;
      slot_r      <= '0;
      evict_r     <= '0;
      busy_cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_fire) state_r <= S_EXEC;
          if (out_valid_r && out_ready) out_valid_r <= 1'b0;
        end
        S_EXEC: begin
          // go implies the previous result is gone or leaves at this edge.
          if (go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            status_r    <= status_nxt;
            slot_r      <= slot_nxt;
            evict_r     <= evict_nxt;
            busy_cnt_r  <= 4'(cnt_nxt);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_action;
      req_r  <= ID_BITS'(in_requester_id);
      high_r <= in_high_priority;
      idx_r  <= in_slot_index;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot_out   = slot_r;
  assign out_evicted_id = evict_r;
  assign out_busy_count = busy_cnt_r;

  // The busy counter tracks the cells' busy flags.
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(busy_vec)) == 32'(cnt_r))
    else $error("busy counter out of step with cell busy flags");

  // Eviction only happens when every unreserved slot is busy.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (go && status_nxt == ST_GRANT_EVICT) |-> (&busy_vec[SLOTS-1:1]))
    else $error("eviction with a free slot available");

  // An accepted request reaches the execute state in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted request did not reach execute");

  // A held result is not overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !go)
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire
